/* rtl/core/pwlm_pkg.sv */
// types and constants shared by the window/level pixel mapper
`default_nettype none

package pwlm_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_BLACK   = 3'd0;
	localparam logic [2:0] REG_WHITE   = 3'd1;
	localparam logic [2:0] REG_REVERSE = 3'd2;
	localparam logic [2:0] REG_MODE    = 3'd3;
	localparam logic [2:0] REG_BLANK   = 3'd4;

	// channel modes, 3-bit two's complement
	localparam logic signed [2:0] MODE_GREY  = 3'sd0;
	localparam logic signed [2:0] MODE_BYTE2 = 3'sd1;
	localparam logic signed [2:0] MODE_BYTE1 = 3'sd2;
	localparam logic signed [2:0] MODE_BYTE0 = 3'sd3;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned RAMP_N  = 256;
	// reciprocal scale: 16-bit dividend plus 8-bit divisor
	localparam int unsigned FRAC_W  = 24;
	localparam int unsigned RECIP_W = FRAC_W + 1;

	// where a pixel falls in the window
	typedef enum logic [1:0] {
		CLS_BLANK,
		CLS_BLACK,
		CLS_WHITE,
		CLS_RAMP
	} pix_class_t;

endpackage

`default_nettype wire

/* rtl/core/pixel_window_level_map.sv */
// window/level contrast mapper for 8-bit grey pixels with word packing
//
// Maps each grey pixel through a black/white window and packs the result into a
// 32-bit word by channel mode. Throughput is one word per clock while m_tready is
// high; the reciprocal table read, the 8x25 multiplier and the output register
// form the pipeline. The ramp division is exact: the reciprocal ceil(2^24/ramp)
// is read from a constant table addressed by white-black and the quotient is the
// upper byte of the product. Configuration is written through cfg_we/cfg_index/
// cfg_data; the user must do so only while no words are in flight (not enforced).
`default_nettype none

module pixel_window_level_map (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [39:0] s_tdata,   // [7:0] pixel, [39:8] prior_word
	input  wire logic        s_tlast,   // last_pixel
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [31:0] out_word
	output      logic        m_tlast    // last_out
);
	import pwlm_pkg::*;

	localparam int unsigned PROD_W = FRAC_W;

	// configuration
	logic [PIX_W-1:0]  black_q;
	logic [PIX_W-1:0]  white_q;
	logic              reverse_q;
	logic signed [2:0] mode_q;
	logic              blank_q;

	// reciprocal table, one entry per ramp width
	logic [RECIP_W-1:0] recip_rom [RAMP_N];

	for (genvar g = 0; g < RAMP_N; g++) begin : g_recip
		localparam int unsigned RV = (g == 0) ? (1 << FRAC_W) :
			(((1 << FRAC_W) + g - 1) / ((g == 0) ? 1 : g));
		assign recip_rom[g] = RECIP_W'(RV);
	end

	// pipeline control
	logic adv1, adv2, adv3;
	logic v1_s1, v2_s2, v3_q;

	// stage 1
	pix_class_t         cls_s1;
	logic [PIX_W-1:0]   n_s1;
	logic [RECIP_W-1:0] recip_s1;
	logic [WORD_W-1:0]  prior_s1;
	logic               last_s1;

	// stage 2
	pix_class_t         cls_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic [WORD_W-1:0]  prior_s2;
	logic               last_s2;

	// output
	logic [WORD_W-1:0]  word_q;
	logic               last_q;

	logic [PIX_W-1:0]   pixel;
	logic [WORD_W-1:0]  prior_word;
	logic [PIX_W-1:0]   ramp;
	pix_class_t         cls_d;
	logic [PIX_W-1:0]   val;
	logic [WORD_W-1:0]  word_d;

	assign pixel      = s_tdata[PIX_W-1:0];
	assign prior_word = s_tdata[PIX_W +: WORD_W];
	assign ramp       = white_q - black_q;

	assign adv3     = !v3_q || m_tready;
	assign adv2     = !v2_s2 || adv3;
	assign adv1     = !v1_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q   <= '0;
			white_q   <= '1;
			reverse_q <= 1'b0;
			mode_q    <= MODE_GREY;
			blank_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLACK:   black_q   <= cfg_data;
				REG_WHITE:   white_q   <= cfg_data;
				REG_REVERSE: reverse_q <= cfg_data[0];
				REG_MODE:    mode_q    <= cfg_data[2:0];
				REG_BLANK:   blank_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// white test wins over black test
	always_comb begin
		if (blank_q)
			cls_d = CLS_BLANK;
		else if (pixel >= white_q)
			cls_d = CLS_WHITE;
		else if (pixel < black_q)
			cls_d = CLS_BLACK;
		else
			cls_d = CLS_RAMP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_q  <= 1'b0;
		end else begin
			if (adv1)
				v1_s1 <= s_tvalid;
			if (adv2)
				v2_s2 <= v1_s1;
			if (adv3)
				v3_q <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			cls_s1   <= cls_d;
			n_s1     <= pixel - black_q;
			recip_s1 <= recip_rom[ramp];
			prior_s1 <= prior_word;
			last_s1  <= s_tlast;
		end
		if (adv2 && v1_s1) begin
			cls_s2   <= cls_s1;
			prod_s2  <= PROD_W'(33'(n_s1) * 33'(recip_s1));
			prior_s2 <= prior_s1;
			last_s2  <= last_s1;
		end
		if (adv3 && v2_s2) begin
			word_q <= word_d;
			last_q <= last_s2;
		end
	end

	// mapped value, quotient is the product shifted down by 16
	always_comb begin
		case (cls_s2)
			CLS_WHITE: val = '1;
			CLS_RAMP:  val = prod_s2[FRAC_W-1 -: PIX_W];
			default:   val = '0;
		endcase
		if (reverse_q && cls_s2 != CLS_BLANK)
			val = ~val;
	end

	always_comb begin
		word_d = prior_s2;
		case (mode_q)
			MODE_GREY:  word_d = {8'h00, val, val, val};
			MODE_BYTE2: word_d[23:16] = val;
			MODE_BYTE1: word_d[15:8] = val;
			MODE_BYTE0: word_d[7:0] = val;
			default:    word_d = {24'h000000, val};
		endcase
	end

	assign m_tvalid = v3_q;
	assign m_tdata  = word_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire
